/* design/ps2mct_pkg.sv */
// package: payload types, config indexes, sizes and byte phase codes for the ps2 cursor tracker
`default_nettype none
package ps2mct_pkg;

  localparam int POS_WIDTH = 8;
  localparam int CALC_W    = POS_WIDTH + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd1;

  localparam logic [7:0] X_LIMIT_RST = 8'd79;
  localparam logic [7:0] Y_LIMIT_RST = 8'd25;
  localparam int         POS_X_RST   = 42;
  localparam int         POS_Y_RST   = 15;

  localparam int STAT_FULL_BIT = 0;
  localparam int STAT_AUX_BIT  = 5;
  localparam int SYNC_BIT      = 3;
  localparam int OVF_X_BIT     = 6;
  localparam int OVF_Y_BIT     = 7;
  localparam int LEFT_BIT      = 0;
  localparam int RIGHT_BIT     = 1;

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_DX  = 2'd1;
  localparam logic [1:0] PH_DY  = 2'd2;

  typedef struct packed {
    logic [7:0] ctrl_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic       left_pressed;
    logic       right_pressed;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

endpackage
`default_nettype wire

/* design/ps2mct_in_reg.sv */
// input register stage holding one request for the decoder
`default_nettype none
module ps2mct_in_reg (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  ps2mct_pkg::in_item_t     in_data,
  input  wire                      take,
  output logic                     stg_vld,
  output ps2mct_pkg::in_item_t     stg_item
);
  import ps2mct_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  // take means the decoder consumes the held request this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stg_vld  = vld_r;
  assign stg_item = item_r;

endmodule
`default_nettype wire

/* design/ps2mct_core.sv */
// packet assembly, cursor update with clamping, and limit registers
`default_nettype none
module ps2mct_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           adv,
  input  ps2mct_pkg::in_item_t          item,
  input  wire                           cfg_valid,
  input  wire [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [7:0]                     cfg_data,
  output ps2mct_pkg::res_t              res
);
  import ps2mct_pkg::*;

  logic [1:0]           phase_r, phase_nxt;
  logic [7:0]           hdr_r, hdr_nxt;
  logic [7:0]           dx_r, dx_nxt;
  logic [POS_WIDTH-1:0] pos_x_r, pos_x_nxt;
  logic [POS_WIDTH-1:0] pos_y_r, pos_y_nxt;
  logic [7:0]           x_lim_r, y_lim_r;

  logic                    counted;
  logic signed [CALC_W-1:0] nx, ny, x_lim_ext, y_lim_ext;
  logic [POS_WIDTH-1:0]    cx, cy;
  logic [POS_WIDTH+7:0]    cx_wide, cy_wide;

  assign counted = item.ctrl_status[STAT_FULL_BIT] && item.ctrl_status[STAT_AUX_BIT];

  assign x_lim_ext = $signed({{(CALC_W-8){1'b0}}, x_lim_r});
  assign y_lim_ext = $signed({{(CALC_W-8){1'b0}}, y_lim_r});
  assign nx = $signed({2'b00, pos_x_r}) + $signed({{(CALC_W-8){dx_r[7]}}, dx_r});
  assign ny = $signed({2'b00, pos_y_r})
            - $signed({{(CALC_W-8){item.rx_byte[7]}}, item.rx_byte});

  always_comb begin
    if (nx > x_lim_ext) begin
      cx = x_lim_ext[POS_WIDTH-1:0];
    end else if (nx < 0) begin
      cx = '0;
    end else begin
      cx = nx[POS_WIDTH-1:0];
    end
    if (ny > y_lim_ext) begin
      cy = y_lim_ext[POS_WIDTH-1:0];
    end else if (ny < 0) begin
      cy = '0;
    end else begin
      cy = ny[POS_WIDTH-1:0];
    end
  end

  assign cx_wide = {8'b0, cx};
  assign cy_wide = {8'b0, cy};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    dx_nxt    = dx_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    res.vld   = 1'b0;
    res.item.cursor_x      = cx_wide[7:0];
    res.item.cursor_y      = cy_wide[7:0];
    res.item.left_pressed  = hdr_r[LEFT_BIT];
    res.item.right_pressed = hdr_r[RIGHT_BIT];
    if (adv && counted) begin
      case (phase_r)
        PH_DX: begin
          dx_nxt    = item.rx_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          phase_nxt = PH_HDR;
          if (!hdr_r[OVF_X_BIT] && !hdr_r[OVF_Y_BIT]) begin
            pos_x_nxt = cx;
            pos_y_nxt = cy;
            res.vld   = 1'b1;
          end
        end
        default: begin
          // header slot, also resyncs from the unused phase
          phase_nxt = PH_HDR;
          if (item.rx_byte[SYNC_BIT]) begin
            hdr_nxt   = item.rx_byte;
            phase_nxt = PH_DX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hdr_r   <= '0;
      dx_r    <= '0;
      pos_x_r <= POS_X_RST[POS_WIDTH-1:0];
      pos_y_r <= POS_Y_RST[POS_WIDTH-1:0];
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      dx_r    <= dx_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lim_r <= X_LIMIT_RST;
      y_lim_r <= Y_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_X_LIMIT) begin
        x_lim_r <= cfg_data;
      end else if (cfg_index == CFG_Y_LIMIT) begin
        y_lim_r <= cfg_data;
      end
    end
  end

  a_res_only_on_dy: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (adv && phase_r == PH_DY))
    else $error("result outside the third byte");

  a_back_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |=> (phase_r == PH_HDR))
    else $error("phase not reset after packet");

  a_hdr_synced: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DX || phase_r == PH_DY) |-> hdr_r[SYNC_BIT])
    else $error("packet in progress without sync bit in header");

  a_ignored_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !counted) |=> ($stable(phase_r) && $stable(pos_x_r) && $stable(pos_y_r)))
    else $error("state changed on a byte that does not count");

endmodule
`default_nettype wire

/* design/ps2mct_out_reg.sv */
// result register toward the receiver
`default_nettype none
module ps2mct_out_reg (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ps2mct_pkg::res_t       res,
  output logic                   free,
  output logic                   out_valid,
  input  wire                    out_ready,
  output ps2mct_pkg::out_item_t  out_data
);
  import ps2mct_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t item_r;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (res.vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      item_r <= res.item;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = item_r;

endmodule
`default_nettype wire

/* design/ps2_mouse_packet_cursor_tracker.sv */
// top level of the ps2 mouse packet decoder with cursor tracking
//
// in_*  : one request per controller read, status byte plus data byte.
//         bytes count only with status bits 0 and 5 set; three counted
//         bytes form a packet, and a packet without overflow moves the
//         cursor (clamped to the limits) and yields one result.
// out_* : cursor column/row and left/right button bits, one per packet without overflow.
// cfg_* : index 0 writes x_limit, index 1 writes y_limit; always ready.
// a result is valid once its third byte has passed the input register
// (loaded by the accepting edge) and then the result register (loaded
// when that byte advances). throughput: one request per cycle while the
// result register is free, set by the single input-to-result pass.
// reset (rst_n low, synchronous): cursor at 42/15, limits 79/25, packet
// assembly back to the header byte, both channels empty.
// a stalled receiver holds the result register; one more request still
// waits in the input register, and in_ready drops after that.
`default_nettype none
module ps2_mouse_packet_cursor_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  ps2mct_pkg::in_item_t             in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output ps2mct_pkg::out_item_t            out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]                        cfg_data
);
  import ps2mct_pkg::*;

  logic     stg_vld, out_free, adv;
  in_item_t stg_item;
  res_t     res;

  assign cfg_ready = 1'b1;
  assign adv       = stg_vld && out_free;

  ps2mct_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (adv),
    .stg_vld  (stg_vld),
    .stg_item (stg_item)
  );

  ps2mct_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (stg_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  ps2mct_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
